@@ rtl/sft_pkg.sv @@
// Shared types, codes and reset values of the framed SPI transport.
`default_nettype none

package sft_pkg;

    localparam int unsigned ActionWidth = 3;
    localparam int unsigned CodeWidth   = 3;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 16;

    typedef enum logic [ActionWidth-1:0] {
        ACT_TICK       = 3'd0,
        ACT_START_SEND = 3'd1,
        ACT_START_RECV = 3'd2,
        ACT_XFER_DONE  = 3'd3,
        ACT_PAYLOAD    = 3'd4
    } t_action;

    typedef enum logic [CodeWidth-1:0] {
        RES_BUSY      = 3'd0,
        RES_OK        = 3'd1,
        RES_TIMEOUT   = 3'd2,
        RES_NOT_READY = 3'd3,
        RES_BAD_PARAM = 3'd4
    } t_code;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_READY_WAIT  = 3'd0,
        CFG_RETRY_LIMIT = 3'd1,
        CFG_READY_CODE  = 3'd2,
        CFG_WRITE_HDR   = 3'd3,
        CFG_READ_HDR    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RECV_WAIT = 4'd1,
        PH_RDY_WAIT  = 4'd2,
        PH_HDR       = 4'd3,
        PH_RETRY_GAP = 4'd4,
        PH_FRAME_GAP = 4'd5,
        PH_SEND_NEED = 4'd6,
        PH_SEND_XFER = 4'd7,
        PH_RECV_XFER = 4'd8
    } t_phase;

    localparam logic [15:0] ReadyWaitReset  = 16'd13000;
    localparam logic [3:0]  RetryLimitReset = 4'd10;
    localparam logic [7:0]  ReadyCodeReset  = 8'hC0;
    localparam logic [7:0]  WriteHdrReset   = 8'h42;
    localparam logic [7:0]  ReadHdrReset    = 8'h81;

    typedef struct packed {
        logic [15:0] ready_wait_ticks;
        logic [3:0]  status_retry_limit;
        logic [7:0]  ready_status_code;
        logic [7:0]  write_header;
        logic [7:0]  read_header;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic        is_receive;
        logic [15:0] wait_counter;
        logic [3:0]  retry_counter;
        logic [15:0] bytes_remaining;
        logic [7:0]  chunk_left;
        logic        header_index;
        logic [7:0]  first_status;
        logic [7:0]  second_status;
        logic [15:0] received_total;
    } t_state;

    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic                   ready_line;
        logic [7:0]             spi_rx_byte;
        logic                   spi_failed;
        logic [7:0]             payload_byte;
        logic [15:0]            length;
        logic [15:0]            recv_wait_ticks;
    } t_item;

    typedef struct packed {
        logic        chip_select_n;
        logic        tx_start;
        logic [7:0]  tx_byte;
        logic        want_payload;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        rx_last;
        logic        finished;
        t_code       result_code;
        logic [15:0] byte_count;
        logic [7:0]  status_one;
        logic [7:0]  status_two;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/sft_step.sv @@
// Next-state and result logic for one event of the framed SPI transport.
`default_nettype none

module sft_step
    import sft_pkg::*;
(
    input  wire t_state  i_state,
    input  wire t_cfg    i_cfg,
    input  wire t_item   i_item,
    output t_state       o_state,
    output t_result      o_result
);

    t_state      nxt;
    logic        tx_start;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        rx_last;
    logic        fin;
    t_code       code;
    logic [3:0]  lim;
    logic [3:0]  retry_inc;
    logic [7:0]  chunk;
    logic [7:0]  chunk_dec;
    logic [15:0] rem_dec;
    logic        cs_low;

    always_comb begin
        nxt       = i_state;
        tx_start  = 1'b0;
        tx_byte   = '0;
        rx_valid  = 1'b0;
        rx_data   = '0;
        rx_last   = 1'b0;
        fin       = 1'b0;
        code      = RES_BUSY;
        lim       = (i_cfg.status_retry_limit == 4'd0) ? 4'd1 : i_cfg.status_retry_limit;
        retry_inc = i_state.retry_counter + 4'd1;
        chunk_dec = i_state.chunk_left - 8'd1;
        rem_dec   = i_state.bytes_remaining - 16'd1;
        // The chunk is the smaller of the bytes still owed and the second status.
        chunk     = (i_state.bytes_remaining < {8'd0, i_item.spi_rx_byte})
                    ? i_state.bytes_remaining[7:0] : i_item.spi_rx_byte;

        unique case (i_item.action)
            ACT_START_SEND, ACT_START_RECV: begin
                if (i_state.phase == PH_IDLE) begin
                    nxt.is_receive = (i_item.action == ACT_START_RECV);
                    if (i_item.length == 16'd0) begin
                        fin  = 1'b1;
                        code = RES_BAD_PARAM;
                    end else if (i_item.action == ACT_START_RECV) begin
                        nxt.bytes_remaining = i_item.length;
                        nxt.received_total  = '0;
                        nxt.wait_counter    = i_item.recv_wait_ticks;
                        nxt.phase           = PH_RECV_WAIT;
                    end else begin
                        nxt.bytes_remaining = i_item.length;
                        nxt.wait_counter    = i_cfg.ready_wait_ticks;
                        nxt.retry_counter   = '0;
                        nxt.phase           = PH_RDY_WAIT;
                    end
                end
            end
            ACT_TICK: begin
                if (i_state.phase == PH_RECV_WAIT || i_state.phase == PH_RDY_WAIT) begin
                    if (i_item.ready_line) begin
                        nxt.retry_counter = '0;
                        nxt.header_index  = 1'b0;
                        nxt.phase         = PH_HDR;
                        tx_start          = 1'b1;
                        tx_byte           = i_state.is_receive ? i_cfg.read_header
                                                               : i_cfg.write_header;
                    end else if (i_state.wait_counter == 16'd0) begin
                        nxt.phase = PH_IDLE;
                        fin       = 1'b1;
                        code      = RES_TIMEOUT;
                    end else begin
                        nxt.wait_counter = i_state.wait_counter - 16'd1;
                    end
                end else if (i_state.phase == PH_RETRY_GAP) begin
                    nxt.header_index = 1'b0;
                    nxt.phase        = PH_HDR;
                    tx_start         = 1'b1;
                    tx_byte          = i_state.is_receive ? i_cfg.read_header
                                                          : i_cfg.write_header;
                end else if (i_state.phase == PH_FRAME_GAP) begin
                    nxt.wait_counter  = i_cfg.ready_wait_ticks;
                    nxt.retry_counter = '0;
                    nxt.phase         = PH_RDY_WAIT;
                end
            end
            ACT_XFER_DONE: begin
                if (i_state.phase == PH_HDR || i_state.phase == PH_SEND_XFER ||
                    i_state.phase == PH_RECV_XFER) begin
                    if (i_item.spi_failed) begin
                        nxt.phase = PH_IDLE;
                        fin       = 1'b1;
                        code      = RES_TIMEOUT;
                    end else if (i_state.phase == PH_HDR) begin
                        if (!i_state.header_index) begin
                            nxt.first_status = i_item.spi_rx_byte;
                            nxt.header_index = 1'b1;
                            tx_start         = 1'b1;
                        end else begin
                            nxt.second_status = i_item.spi_rx_byte;
                            if (i_state.first_status == i_cfg.ready_status_code &&
                                i_item.spi_rx_byte != 8'd0) begin
                                nxt.chunk_left = chunk;
                                if (i_state.is_receive) begin
                                    nxt.bytes_remaining = {8'd0, chunk};
                                    nxt.phase           = PH_RECV_XFER;
                                    tx_start            = 1'b1;
                                end else begin
                                    nxt.phase = PH_SEND_NEED;
                                end
                            end else begin
                                nxt.retry_counter = retry_inc;
                                if (retry_inc >= lim) begin
                                    nxt.phase = PH_IDLE;
                                    fin       = 1'b1;
                                    code      = RES_NOT_READY;
                                end else begin
                                    nxt.phase = PH_RETRY_GAP;
                                end
                            end
                        end
                    end else if (i_state.phase == PH_SEND_XFER) begin
                        nxt.chunk_left      = chunk_dec;
                        nxt.bytes_remaining = rem_dec;
                        if (chunk_dec != 8'd0) begin
                            nxt.phase = PH_SEND_NEED;
                        end else if (rem_dec == 16'd0) begin
                            nxt.phase = PH_IDLE;
                            fin       = 1'b1;
                            code      = RES_OK;
                        end else begin
                            nxt.phase = PH_FRAME_GAP;
                        end
                    end else begin
                        rx_valid           = 1'b1;
                        rx_data            = i_item.spi_rx_byte;
                        nxt.received_total = i_state.received_total + 16'd1;
                        nxt.chunk_left     = chunk_dec;
                        if (chunk_dec == 8'd0) begin
                            rx_last   = 1'b1;
                            nxt.phase = PH_IDLE;
                            fin       = 1'b1;
                            code      = RES_OK;
                        end else begin
                            tx_start = 1'b1;
                        end
                    end
                end
            end
            ACT_PAYLOAD: begin
                if (i_state.phase == PH_SEND_NEED) begin
                    nxt.phase = PH_SEND_XFER;
                    tx_start  = 1'b1;
                    tx_byte   = i_item.payload_byte;
                end
            end
            default: begin
                // Undefined actions leave everything as it stands.
            end
        endcase

        cs_low = (nxt.phase == PH_RDY_WAIT) || (nxt.phase == PH_HDR) ||
                 (nxt.phase == PH_SEND_NEED) || (nxt.phase == PH_SEND_XFER) ||
                 (nxt.phase == PH_RECV_XFER);

        o_state                = nxt;
        o_result.chip_select_n = ~cs_low;
        o_result.tx_start      = tx_start;
        o_result.tx_byte       = tx_byte;
        o_result.want_payload  = (nxt.phase == PH_SEND_NEED);
        o_result.rx_valid      = rx_valid;
        o_result.rx_data       = rx_data;
        o_result.rx_last       = rx_last;
        o_result.finished      = fin;
        o_result.result_code   = code;
        o_result.byte_count    = nxt.received_total;
        o_result.status_one    = nxt.first_status;
        o_result.status_two    = nxt.second_status;
    end

endmodule

`default_nettype wire

@@ rtl/spi_hci_frame_transport_top.sv @@
// Latency: the result of an event transaction is valid in the cycle after it is accepted.
// Throughput: one event per cycle; state updates at acceptance, the result register
// decouples the output, so input is taken whenever that register is empty or being emptied.
// Reset (synchronous, active low) returns to idle with the configuration at its defaults.
// The configuration port is always ready; writes to unknown indexes are dropped.
`default_nettype none

module spi_hci_frame_transport_top
    import sft_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Event channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [ActionWidth-1:0]  i_action,
    input  wire logic                    i_ready_line,
    input  wire logic [7:0]              i_spi_rx_byte,
    input  wire logic                    i_spi_failed,
    input  wire logic [7:0]              i_payload_byte,
    input  wire logic [15:0]             i_length,
    input  wire logic [15:0]             i_recv_wait_ticks,
    // Result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_chip_select_n,
    output logic                         o_tx_start,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_want_payload,
    output logic                         o_rx_valid,
    output logic [7:0]                   o_rx_data,
    output logic                         o_rx_last,
    output logic                         o_finished,
    output logic [CodeWidth-1:0]         o_result_code,
    output logic [15:0]                  o_byte_count,
    output logic [7:0]                   o_status_one,
    output logic [7:0]                   o_status_two,
    // Configuration write channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data
);

    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    t_item   item;
    logic    in_fire;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid & o_in_ready;

    assign item.action          = i_action;
    assign item.ready_line      = i_ready_line;
    assign item.spi_rx_byte     = i_spi_rx_byte;
    assign item.spi_failed      = i_spi_failed;
    assign item.payload_byte    = i_payload_byte;
    assign item.length          = i_length;
    assign item.recv_wait_ticks = i_recv_wait_ticks;

    sft_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_wait_ticks   <= ReadyWaitReset;
            r_cfg.status_retry_limit <= RetryLimitReset;
            r_cfg.ready_status_code  <= ReadyCodeReset;
            r_cfg.write_header       <= WriteHdrReset;
            r_cfg.read_header        <= ReadHdrReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_READY_WAIT:  r_cfg.ready_wait_ticks   <= i_cfg_data;
                CFG_RETRY_LIMIT: r_cfg.status_retry_limit <= i_cfg_data[3:0];
                CFG_READY_CODE:  r_cfg.ready_status_code  <= i_cfg_data[7:0];
                CFG_WRITE_HDR:   r_cfg.write_header       <= i_cfg_data[7:0];
                CFG_READ_HDR:    r_cfg.read_header        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chip_select_n = r_res.chip_select_n;
    assign o_tx_start      = r_res.tx_start;
    assign o_tx_byte       = r_res.tx_byte;
    assign o_want_payload  = r_res.want_payload;
    assign o_rx_valid      = r_res.rx_valid;
    assign o_rx_data       = r_res.rx_data;
    assign o_rx_last       = r_res.rx_last;
    assign o_finished      = r_res.finished;
    assign o_result_code   = r_res.result_code;
    assign o_byte_count    = r_res.byte_count;
    assign o_status_one    = r_res.status_one;
    assign o_status_two    = r_res.status_two;

endmodule

`default_nettype wire

@@ dv/spi_hci_frame_transport_top_test.sv @@
// Self-checking testbench for the framed SPI transport: directed table, then guided random events.
module spi_hci_frame_transport_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sft_pkg::*;

    localparam int unsigned     CycleLimit   = 400000;
    localparam int unsigned     PhaseItems   = 200;
    localparam logic [2:0]      ActUnused    = 3'd7;

    typedef struct {
        t_item   ev;
        bit      typed;
        t_result want;
    } t_row;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             ev_valid = 1'b0;
    t_item            ev_item = '0;
    logic             res_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    t_cfg_idx         cfg_index = CFG_READY_WAIT;
    logic [15:0]      cfg_data = '0;

    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_chip_select_n;
    logic             o_tx_start;
    logic [7:0]       o_tx_byte;
    logic             o_want_payload;
    logic             o_rx_valid;
    logic [7:0]       o_rx_data;
    logic             o_rx_last;
    logic             o_finished;
    logic [CodeWidth-1:0] o_result_code;
    logic [15:0]      o_byte_count;
    logic [7:0]       o_status_one;
    logic [7:0]       o_status_two;
    logic             o_cfg_ready;

    // Transport state as this bench tracks it.
    t_cfg             tp_cfg;
    t_phase           tp_phase;
    logic             tp_rx_dir;
    logic [15:0]      tp_wait_left;
    logic [3:0]       tp_tries;
    logic [15:0]      tp_remaining;
    logic [7:0]       tp_chunk;
    logic             tp_second_hdr;
    logic [7:0]       tp_status1;
    logic [7:0]       tp_status2;
    logic [15:0]      tp_rx_total;
    t_result          tp_out;
    bit               tp_acted;

    t_result          pending_results[$];
    t_row             dir_rows[$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    bit               ev_burst = 1'b0;
    bit               res_burst = 1'b0;

    spi_hci_frame_transport_top i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (ev_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (ev_item.action),
        .i_ready_line      (ev_item.ready_line),
        .i_spi_rx_byte     (ev_item.spi_rx_byte),
        .i_spi_failed      (ev_item.spi_failed),
        .i_payload_byte    (ev_item.payload_byte),
        .i_length          (ev_item.length),
        .i_recv_wait_ticks (ev_item.recv_wait_ticks),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (res_ready),
        .o_chip_select_n   (o_chip_select_n),
        .o_tx_start        (o_tx_start),
        .o_tx_byte         (o_tx_byte),
        .o_want_payload    (o_want_payload),
        .o_rx_valid        (o_rx_valid),
        .o_rx_data         (o_rx_data),
        .o_rx_last         (o_rx_last),
        .o_finished        (o_finished),
        .o_result_code     (o_result_code),
        .o_byte_count      (o_byte_count),
        .o_status_one      (o_status_one),
        .o_status_two      (o_status_two),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAIL spi_hci_frame_transport_top");
            $finish;
        end
    end

    function automatic void tp_reset();
        tp_cfg = '{ReadyWaitReset, RetryLimitReset, ReadyCodeReset, WriteHdrReset, ReadHdrReset};
        tp_phase = PH_IDLE;
        tp_rx_dir = 1'b0;
        tp_wait_left = '0;
        tp_tries = '0;
        tp_remaining = '0;
        tp_chunk = '0;
        tp_second_hdr = 1'b0;
        tp_status1 = '0;
        tp_status2 = '0;
        tp_rx_total = '0;
    endfunction

    function automatic void tp_finish(input t_code code);
        tp_phase = PH_IDLE;
        tp_out.finished = 1'b1;
        tp_out.result_code = code;
    endfunction

    function automatic void tp_request(input logic [7:0] b);
        tp_out.tx_start = 1'b1;
        tp_out.tx_byte = b;
    endfunction

    function automatic void tp_start_header();
        tp_second_hdr = 1'b0;
        tp_phase = PH_HDR;
        tp_request(tp_rx_dir ? tp_cfg.read_header : tp_cfg.write_header);
    endfunction

    function automatic void tp_open_frame();
        tp_wait_left = tp_cfg.ready_wait_ticks;
        tp_tries = '0;
        tp_phase = PH_RDY_WAIT;
    endfunction

    // Advances the transport state by one event and returns the outputs it should show.
    function automatic t_result transport_step(input t_item e);
        logic [3:0] limit;
        tp_out = '0;
        tp_acted = 1'b1;
        case (e.action)
            ACT_START_SEND, ACT_START_RECV: begin
                if (tp_phase == PH_IDLE) begin
                    tp_rx_dir = (e.action == ACT_START_RECV);
                    if (e.length == 16'd0) begin
                        tp_finish(RES_BAD_PARAM);
                    end else if (tp_rx_dir) begin
                        tp_remaining = e.length;
                        tp_rx_total = '0;
                        tp_wait_left = e.recv_wait_ticks;
                        tp_phase = PH_RECV_WAIT;
                    end else begin
                        tp_remaining = e.length;
                        tp_open_frame();
                    end
                end else begin
                    tp_acted = 1'b0;
                end
            end
            ACT_TICK: begin
                case (tp_phase)
                    PH_RECV_WAIT, PH_RDY_WAIT: begin
                        if (e.ready_line) begin
                            tp_tries = '0;
                            tp_start_header();
                        end else if (tp_wait_left == 16'd0) begin
                            tp_finish(RES_TIMEOUT);
                        end else begin
                            tp_wait_left = tp_wait_left - 16'd1;
                        end
                    end
                    PH_RETRY_GAP: tp_start_header();
                    PH_FRAME_GAP: tp_open_frame();
                    default: tp_acted = 1'b0;
                endcase
            end
            ACT_XFER_DONE: begin
                if (tp_phase != PH_HDR && tp_phase != PH_SEND_XFER && tp_phase != PH_RECV_XFER) begin
                    tp_acted = 1'b0;
                end else if (e.spi_failed) begin
                    tp_finish(RES_TIMEOUT);
                end else if (tp_phase == PH_HDR) begin
                    if (!tp_second_hdr) begin
                        tp_status1 = e.spi_rx_byte;
                        tp_second_hdr = 1'b1;
                        tp_request(8'h00);
                    end else begin
                        tp_status2 = e.spi_rx_byte;
                        if (tp_status1 == tp_cfg.ready_status_code && tp_status2 != 8'd0) begin
                            tp_chunk = (tp_remaining < {8'h00, tp_status2}) ? tp_remaining[7:0]
                                                                            : tp_status2;
                            if (tp_rx_dir) begin
                                tp_remaining = {8'h00, tp_chunk};
                                tp_phase = PH_RECV_XFER;
                                tp_request(8'h00);
                            end else begin
                                tp_phase = PH_SEND_NEED;
                            end
                        end else begin
                            limit = (tp_cfg.status_retry_limit == 4'd0) ? 4'd1
                                                                         : tp_cfg.status_retry_limit;
                            tp_tries = tp_tries + 4'd1;
                            if (tp_tries >= limit) begin
                                tp_finish(RES_NOT_READY);
                            end else begin
                                tp_phase = PH_RETRY_GAP;
                            end
                        end
                    end
                end else if (tp_phase == PH_SEND_XFER) begin
                    tp_chunk = tp_chunk - 8'd1;
                    tp_remaining = tp_remaining - 16'd1;
                    if (tp_chunk != 8'd0) begin
                        tp_phase = PH_SEND_NEED;
                    end else if (tp_remaining == 16'd0) begin
                        tp_finish(RES_OK);
                    end else begin
                        tp_phase = PH_FRAME_GAP;
                    end
                end else begin
                    tp_out.rx_valid = 1'b1;
                    tp_out.rx_data = e.spi_rx_byte;
                    tp_rx_total = tp_rx_total + 16'd1;
                    tp_chunk = tp_chunk - 8'd1;
                    if (tp_chunk == 8'd0) begin
                        tp_out.rx_last = 1'b1;
                        tp_finish(RES_OK);
                    end else begin
                        tp_request(8'h00);
                    end
                end
            end
            ACT_PAYLOAD: begin
                if (tp_phase == PH_SEND_NEED) begin
                    tp_phase = PH_SEND_XFER;
                    tp_request(e.payload_byte);
                end else begin
                    tp_acted = 1'b0;
                end
            end
            default: tp_acted = 1'b0;
        endcase
        case (tp_phase)
            PH_RDY_WAIT, PH_HDR, PH_SEND_NEED, PH_SEND_XFER, PH_RECV_XFER:
                tp_out.chip_select_n = 1'b0;
            default: tp_out.chip_select_n = 1'b1;
        endcase
        tp_out.want_payload = (tp_phase == PH_SEND_NEED);
        tp_out.byte_count = tp_rx_total;
        tp_out.status_one = tp_status1;
        tp_out.status_two = tp_status2;
        return tp_out;
    endfunction

    function automatic t_item mk_ev(input logic [2:0] action, input logic rdy,
                                    input logic [7:0] rxb, input logic fail,
                                    input logic [7:0] pay, input logic [15:0] len,
                                    input logic [15:0] rwait);
        return '{action, rdy, rxb, fail, pay, len, rwait};
    endfunction

    function automatic t_result done_result(input t_code code, input logic fin);
        t_result r;
        r = '0;
        r.chip_select_n = 1'b1;
        r.finished = fin;
        r.result_code = code;
        return r;
    endfunction

    // Picks the event that moves the current operation on, with some noise mixed in.
    function automatic t_item next_event();
        t_item e;
        int unsigned pick;
        e.action = ACT_TICK;
        e.ready_line = 1'($urandom);
        e.spi_rx_byte = 8'($urandom);
        e.spi_failed = 1'b0;
        e.payload_byte = 8'($urandom);
        e.length = 16'($urandom);
        e.recv_wait_ticks = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            e.action = 3'($urandom);
            e.spi_failed = 1'($urandom);
            return e;
        end
        case (tp_phase)
            PH_IDLE: begin
                e.action = $urandom_range(0, 1) ? ACT_START_SEND : ACT_START_RECV;
                pick = $urandom_range(0, 19);
                e.length = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF
                                                             : 16'($urandom_range(1, 12));
                e.recv_wait_ticks = ($urandom_range(0, 15) == 0) ? 16'hFFFF
                                                                 : 16'($urandom_range(0, 3));
            end
            PH_RECV_WAIT, PH_RDY_WAIT, PH_RETRY_GAP, PH_FRAME_GAP: begin
                e.action = ACT_TICK;
                e.ready_line = ($urandom_range(0, 2) != 0);
            end
            PH_HDR: begin
                e.action = ACT_XFER_DONE;
                // Very long sends are cut short by a bus error to keep the run brief.
                e.spi_failed = ($urandom_range(0, 39) == 0) ||
                               (tp_remaining > 16'd600 && $urandom_range(0, 1) == 1);
                if (!tp_second_hdr) begin
                    if ($urandom_range(0, 3) != 0) e.spi_rx_byte = tp_cfg.ready_status_code;
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) e.spi_rx_byte = 8'd0;
                    else if (pick != 1) e.spi_rx_byte = 8'($urandom_range(1, 8));
                end
            end
            PH_SEND_NEED: e.action = ACT_PAYLOAD;
            default: begin
                e.action = ACT_XFER_DONE;
                e.spi_failed = ($urandom_range(0, 59) == 0);
            end
        endcase
        return e;
    endfunction

    task automatic push_event(input t_item e, input bit typed, input t_result want);
        int unsigned gap;
        t_result predicted;
        gap = ev_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0) ev_burst = !ev_burst;
        @(negedge clk);
        if (gap != 0) begin
            ev_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_valid <= 1'b1;
        ev_item <= e;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        predicted = transport_step(e);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        @(negedge clk);
        ev_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            CFG_READY_WAIT:  tp_cfg.ready_wait_ticks = data;
            CFG_RETRY_LIMIT: tp_cfg.status_retry_limit = data[3:0];
            CFG_READY_CODE:  tp_cfg.ready_status_code = data[7:0];
            CFG_WRITE_HDR:   tp_cfg.write_header = data[7:0];
            CFG_READ_HDR:    tp_cfg.read_header = data[7:0];
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry noise; the block must drop it.
    task automatic apply_settings(input t_cfg s);
        write_reg(CFG_READY_WAIT, s.ready_wait_ticks);
        write_reg(CFG_RETRY_LIMIT, {12'($urandom), s.status_retry_limit});
        write_reg(CFG_READY_CODE, {8'($urandom), s.ready_status_code});
        write_reg(CFG_WRITE_HDR, {8'($urandom), s.write_header});
        write_reg(CFG_READ_HDR, {8'($urandom), s.read_header});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && o_out_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction arrived with nothing expected", $time);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("chip_select_n", want.chip_select_n, o_chip_select_n);
                cmp_field("tx_start", want.tx_start, o_tx_start);
                cmp_field("tx_byte", want.tx_byte, o_tx_byte);
                cmp_field("want_payload", want.want_payload, o_want_payload);
                cmp_field("rx_valid", want.rx_valid, o_rx_valid);
                cmp_field("rx_data", want.rx_data, o_rx_data);
                cmp_field("rx_last", want.rx_last, o_rx_last);
                cmp_field("finished", want.finished, o_finished);
                cmp_field("result_code", want.result_code, o_result_code);
                cmp_field("byte_count", want.byte_count, o_byte_count);
                cmp_field("status_one", want.status_one, o_status_one);
                cmp_field("status_two", want.status_two, o_status_two);
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = res_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0) res_burst = !res_burst;
            if (stall != 0) begin
                @(negedge clk);
                res_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ready <= 1'b1;
            @(posedge clk);
            while (!(o_out_valid && res_ready)) @(posedge clk);
        end
    end

    initial begin : stimulus
        t_cfg        settings [6];
        t_result     quiet;
        t_result     no_care;
        int unsigned counted;

        tp_reset();
        quiet = done_result(RES_BUSY, 1'b0);
        no_care = '0;
        settings[0] = '{16'd3, 4'd10, 8'hC0, 8'h42, 8'h81};
        settings[1] = '{16'd0, 4'd0, 8'hFF, 8'h00, 8'hFF};
        settings[2] = '{16'hFFFF, 4'd15, 8'h00, 8'hFF, 8'h00};
        settings[3] = '{16'd1, 4'd1, 8'h5A, 8'hA5, 8'h3C};
        settings[4] = '{16'($urandom_range(0, 7)), 4'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom)};
        settings[5] = '{16'd2, 4'd3, ReadyCodeReset, WriteHdrReset, ReadHdrReset};

        // Idle and illegal events first, then a two-frame send with one retry, then a
        // receive that times out on its very first tick.
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b1, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF),
                             1'b1, quiet});
        dir_rows.push_back('{mk_ev(ACT_START_SEND, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b1, done_result(RES_BAD_PARAM, 1'b1)});
        dir_rows.push_back('{mk_ev(ACT_START_RECV, 1'b1, 8'h00, 1'b0, 8'h00, 16'd0, 16'hFFFF),
                             1'b1, done_result(RES_BAD_PARAM, 1'b1)});
        dir_rows.push_back('{mk_ev(ActUnused, 1'b1, 8'hFF, 1'b1, 8'hFF, 16'd5, 16'd5),
                             1'b1, quiet});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'hC0, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b1, quiet});
        dir_rows.push_back('{mk_ev(ACT_PAYLOAD, 1'b0, 8'h00, 1'b0, 8'hAA, 16'd0, 16'd0),
                             1'b1, quiet});
        dir_rows.push_back('{mk_ev(ACT_START_SEND, 1'b0, 8'h00, 1'b0, 8'h00, 16'd3, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b1, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'hC0, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h02, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_PAYLOAD, 1'b0, 8'h00, 1'b0, 8'hFF, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_PAYLOAD, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b1, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'hC0, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'hFF, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_PAYLOAD, 1'b0, 8'h00, 1'b0, 8'h5A, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_XFER_DONE, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_START_RECV, 1'b0, 8'h00, 1'b0, 8'h00, 16'hFFFF, 16'd0),
                             1'b0, no_care});
        dir_rows.push_back('{mk_ev(ACT_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 16'd0, 16'd0),
                             1'b0, no_care});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

        // Each setting runs until enough effective events have gone and the transport is idle.
        for (int p = 0; p < 6; p++) begin
            settle();
            apply_settings(settings[p]);
            counted = 0;
            while (counted < PhaseItems || tp_phase != PH_IDLE) begin
                push_event(next_event(), 1'b0, no_care);
                if (tp_acted) counted++;
                if ($urandom_range(0, 299) == 0) settle();
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS spi_hci_frame_transport_top");
        end else begin
            $display("FAIL spi_hci_frame_transport_top");
        end
        $finish;
    end

endmodule
